@@ rtl/core/skl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and codes for the sorted key list: request and status codes,
// controller states and the per-cycle control word sent down the cell chain.
// ----------------------------------------------------------------------------
package skl_pkg;

	localparam int KEY_W = 32;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_POP    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_RED,
		S_COMMIT,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		ACT_HOLD,
		ACT_INS,
		ACT_DEL,
		ACT_POP
	} act_t;

	typedef struct packed {
		logic cmp_en;
		act_t act;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/sorted_key_list.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_list
// Bounded ascending multiset of signed 32-bit keys held in a chain of cells.
//
//  channel   signals                                        direction
//  request   start, busy, req_type, key                     in (busy out)
//  result    done, found, status, smallest_key,             out
//            is_empty, key_count
//
// An accepted request passes through S_CMP, S_RED, S_COMMIT and S_RESP in that
// order; in S_RED the list waits for the registered OR tree that finds a match.
// The next request can be accepted only after the return to S_IDLE, so a new
// request is not taken before the last one has shown its result.
// busy is high from the accepting edge until done has been shown.
// done is high for one cycle; the receiver cannot stall it.
// Reset empties the list; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_list #(
	parameter int CAPACITY = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire [1:0]                        req_type,
	input  wire signed [skl_pkg::KEY_W-1:0]  key,
	output logic                             done,
	output logic                             found,
	output logic [1:0]                       status,
	output logic signed [skl_pkg::KEY_W-1:0] smallest_key,
	output logic                             is_empty,
	output logic [4:0]                       key_count
);
	import skl_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int LEVELS = $clog2(CAPACITY);
	localparam int RC_W   = $clog2(LEVELS + 1);

	state_t state_q, state_d;
	cell_ctrl_t ctrl;
	logic [RC_W-1:0] red_q;
	req_t req_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic found_q, found_d;
	status_t status_q, status_d;
	logic any_hit;
	logic [CNT_W+4:0] count_ext;

	logic signed [KEY_W-1:0] slot_w [CAPACITY];
	logic [CAPACITY-1:0] ge_w;
	logic [CAPACITY-1:0] hit_w;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skl_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.count      (count_q),
			.key        (key_q),
			.left_slot  (i == 0 ? key_q : slot_w[(i == 0) ? 0 : i - 1]),
			.left_ge    (i == 0 ? 1'b0 : ge_w[(i == 0) ? 0 : i - 1]),
			.right_slot (i == CAPACITY - 1 ? slot_w[i] :
				slot_w[(i == CAPACITY - 1) ? i : i + 1]),
			.slot_q     (slot_w[i]),
			.ge_q       (ge_w[i]),
			.hit_q      (hit_w[i])
		);
	end

	skl_or_tree #(
		.N (CAPACITY)
	) u_tree (
		.clk   (clk),
		.hits  (hit_w),
		.any_q (any_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		ctrl.cmp_en = 1'b0;
		ctrl.act    = ACT_HOLD;
		count_d     = count_q;
		found_d     = 1'b0;
		status_d    = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_CMP;
			end
			S_CMP: begin
				ctrl.cmp_en = 1'b1;
				state_d     = S_RED;
			end
			S_RED: begin
				if (red_q == RC_W'(LEVELS - 1))
					state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_RESP;
				case (req_q)
					REQ_INSERT: begin
						if (count_q == CNT_W'(CAPACITY)) begin
							status_d = ST_FULL;
						end else begin
							ctrl.act = ACT_INS;
							count_d  = count_q + CNT_W'(1);
						end
					end
					REQ_REMOVE: begin
						if (any_hit) begin
							ctrl.act = ACT_DEL;
							found_d  = 1'b1;
							count_d  = count_q - CNT_W'(1);
						end else begin
							status_d = ST_MISS;
						end
					end
					REQ_SEARCH: found_d = any_hit;
					REQ_POP: begin
						if (count_q != '0) begin
							ctrl.act = ACT_POP;
							found_d  = 1'b1;
							count_d  = count_q - CNT_W'(1);
						end else begin
							status_d = ST_MISS;
						end
					end
					default: status_d = ST_OK;
				endcase
			end
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			red_q    <= '0;
			found_q  <= 1'b0;
			status_q <= ST_OK;
		end else begin
			count_q <= count_d;
			if (state_q == S_RED)
				red_q <= red_q + RC_W'(1);
			else
				red_q <= '0;
			if (state_q == S_COMMIT) begin
				found_q  <= found_d;
				status_q <= status_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req_t'(req_type);
			key_q <= key;
		end
	end

	assign count_ext    = {5'b0, count_q};
	assign busy         = state_q != S_IDLE;
	assign done         = state_q == S_RESP;
	assign found        = found_q;
	assign status       = status_q;
	assign is_empty     = count_q == '0;
	assign smallest_key = (count_q == '0) ? '0 : slot_w[0];
	assign key_count    = count_ext[4:0];

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> state_q == S_CMP)
		else $error("accepted request did not enter compare");

	a_done_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_COMMIT)
		else $error("result shown without commit");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_error_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && status_q != ST_OK) |-> count_q == $past(count_q))
		else $error("failed request changed the count");

	a_removal_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && found_q && req_q != REQ_SEARCH)
			|-> count_q == $past(count_q) - CNT_W'(1))
		else $error("removal did not drop exactly one key");

endmodule
`default_nettype wire

@@ rtl/core/skl_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skl_cell
// One slot of the sorted chain. Compares its key against the request key,
// then shifts right on insert or left on removal from its neighbors.
// ----------------------------------------------------------------------------
module skl_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  skl_pkg::cell_ctrl_t              ctrl,
	input  wire [CNT_W-1:0]                  count,
	input  wire signed [skl_pkg::KEY_W-1:0]  key,
	input  wire signed [skl_pkg::KEY_W-1:0]  left_slot,
	input  wire                              left_ge,
	input  wire signed [skl_pkg::KEY_W-1:0]  right_slot,
	output logic signed [skl_pkg::KEY_W-1:0] slot_q,
	output logic                             ge_q,
	output logic                             hit_q
);
	import skl_pkg::*;

	logic occ;
	logic ge;
	logic signed [KEY_W-1:0] slot_d;

	// empty slots sort as +infinity
	assign occ = CNT_W'(IDX) < count;
	assign ge  = !occ || (slot_q >= key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q  <= 1'b0;
			hit_q <= 1'b0;
		end else if (ctrl.cmp_en) begin
			ge_q  <= ge;
			hit_q <= occ && (slot_q == key);
		end
	end

	always_comb begin
		slot_d = slot_q;
		case (ctrl.act)
			ACT_INS: begin
				if (ge_q)
					slot_d = left_ge ? left_slot : key;
			end
			ACT_DEL: begin
				if (ge_q)
					slot_d = right_slot;
			end
			ACT_POP: slot_d = right_slot;
			default: slot_d = slot_q;
		endcase
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

endmodule
`default_nettype wire

@@ rtl/core/skl_or_tree.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// skl_or_tree
// Registered OR reduction of the per-cell match flags, with one register level
// per tree level.
// ----------------------------------------------------------------------------
module skl_or_tree #(
	parameter int N = 16
) (
	input  wire         clk,
	input  wire [N-1:0] hits,
	output logic        any_q
);
	localparam int LEVELS = $clog2(N);
	localparam int P      = 1 << LEVELS;

	logic [P-1:0] leaf_w;
	logic [P-2:0] node_q;

	for (genvar j = 0; j < P; j++) begin : g_leaf
		if (j < N) begin : g_real
			assign leaf_w[j] = hits[j];
		end else begin : g_pad
			assign leaf_w[j] = 1'b0;
		end
	end

	for (genvar n = 0; n < P - 1; n++) begin : g_node
		if (2 * n + 1 >= P - 1) begin : g_from_leaf
			always_ff @(posedge clk) begin
				node_q[n] <= leaf_w[2 * n + 1 - (P - 1)] | leaf_w[2 * n + 2 - (P - 1)];
			end
		end else begin : g_from_node
			always_ff @(posedge clk) begin
				node_q[n] <= node_q[2 * n + 1] | node_q[2 * n + 2];
			end
		end
	end

	assign any_q = node_q[0];

endmodule
`default_nettype wire
